@@ src/latency_histogram_percentile_macros.svh @@
// Assertion macros shared by the checker.
`ifndef LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILE_MACROS_SVH
`define LHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define LHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ src/lhp_pkg.sv @@
package lhp_pkg;
	localparam int MaxBuckets = 1024;
	localparam int IdxW = $clog2(MaxBuckets);
	localparam logic [31:0] MinReset = 32'd999999999;
	localparam logic [29:0] EdgeMax = 30'h3FFFFFFF;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_QUERY = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;
	localparam logic [1:0] KIND_READ = 2'd3;

	localparam logic REG_NUM_BUCKETS = 1'b0;
	localparam logic REG_NS_PER_BUCKET = 1'b1;

	typedef struct packed {
		logic [1:0] kind;
		logic [31:0] sample_ns;
		logic [16:0] percentile_milli;
		logic [9:0] bucket_index;
	} lhp_in_t;

	typedef struct packed {
		logic [29:0] percentile_ns;
		logic percentile_found;
		logic [31:0] bucket_value;
		logic [31:0] sample_count;
		logic [63:0] sample_sum;
		logic [31:0] min_sample;
		logic [31:0] max_sample;
		logic [31:0] overflow_count;
	} lhp_out_t;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_DIV, ST_SRD, ST_SWR, ST_WALK,
		ST_WALK2, ST_EMUL, ST_RRD, ST_DONE
	} lhp_state_t;
endpackage

@@ src/lhp_divider.sv @@
// Restoring divider, one quotient bit per cycle.
module lhp_divider import lhp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [47:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [47:0] quotient
);
	logic [47:0] quot_q;
	logic [32:0] rem_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quot_q[47]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd47;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quot_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			if (trial >= {1'b0, divisor}) begin
				rem_q <= trial - {1'b0, divisor};
				quot_q <= {quot_q[46:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[46:0], 1'b0};
			end
		end
	end

	assign quotient = quot_q;
endmodule

@@ src/latency_histogram_percentile.sv @@
// From the input transfer to the result strobe: a sample passes ST_DIV (48-bit
// serial divide), then read and write back; a query passes ST_WALK and ST_WALK2 for
// each bucket walked, plus ST_EMUL when the percentile is found; a read ST_RRD; a clear a pass over all buckets.
// Items are processed one at a time; busy drops in the cycle of the result strobe,
// so the next transfer can be taken there. The receiver cannot stall results.
// After reset a pass zeroes the bucket memory with busy held high.
module latency_histogram_percentile import lhp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input lhp_in_t in_data,
	output logic done,
	output lhp_out_t out_data,
	input logic cfg_we,
	input logic cfg_index,
	input logic [19:0] cfg_wdata
);
	logic [31:0] mem [MaxBuckets];
	logic [31:0] rd_s1;
	logic [IdxW-1:0] addr;
	logic we;
	logic [31:0] wd;

	lhp_state_t state_q, state_d;
	lhp_in_t item_q;
	logic boot_q;
	logic [10:0] nb_q;
	logic [19:0] npb_q;
	logic [31:0] count_q, min_q, max_q, ovf_q;
	logic [63:0] sum_q;
	logic [IdxW:0] ptr_q;
	logic [63:0] acc_q;
	logic [48:0] needed_q;
	logic [48:0] prod_q;
	logic [31:0] bval_q;
	logic [29:0] edge_q;
	logic found_q;

	logic [10:0] used;
	logic [19:0] width;
	logic div_go, div_done;
	logic [47:0] div_a, quot;
	logic [63:0] rd_ext, rd_scaled;

	assign used = (nb_q > 11'(MaxBuckets)) ? 11'(MaxBuckets) : nb_q;
	assign width = (npb_q == '0) ? 20'd1 : npb_q;

	// The walk keeps the running bucket total times 100000, so it is compared with
	// count * pct directly and no division is needed. 100000 is 2^16+2^15+2^10+2^9+2^7+2^5.
	assign rd_ext = {32'd0, rd_s1};
	assign rd_scaled = (rd_ext << 16) + (rd_ext << 15) + (rd_ext << 10) + (rd_ext << 9)
		+ (rd_ext << 7) + (rd_ext << 5);

	lhp_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a),
		.divisor({12'd0, width}), .done(div_done), .quotient(quot)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: if (ptr_q == (IdxW+1)'(MaxBuckets - 1)) begin
				state_d = boot_q ? ST_IDLE : ST_DONE;
			end
			ST_IDLE: if (start) begin
				case (in_data.kind)
					KIND_SAMPLE: state_d = ST_DIV;
					KIND_QUERY: state_d = ST_WALK;
					KIND_CLEAR: state_d = ST_INIT;
					default: state_d = ST_RRD;
				endcase
			end
			ST_DIV: if (div_done) state_d = ST_SRD;
			ST_SRD: state_d = ST_SWR;
			ST_SWR: state_d = ST_DONE;
			ST_WALK: begin
				if (acc_q > {15'd0, needed_q}) state_d = ST_EMUL;
				else if (ptr_q >= (IdxW+1)'(used)) state_d = ST_DONE;
				else state_d = ST_WALK2;
			end
			ST_WALK2: state_d = ST_WALK;
			ST_EMUL: state_d = ST_DONE;
			ST_RRD: state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		div_go = (state_q == ST_IDLE && start && in_data.kind == KIND_SAMPLE);
		div_a = {16'd0, in_data.sample_ns};
		we = 1'b0;
		wd = '0;
		addr = ptr_q[IdxW-1:0];
		case (state_q)
			ST_INIT: we = 1'b1;
			ST_SRD: addr = quot[IdxW-1:0];
			ST_SWR: begin
				addr = quot[IdxW-1:0];
				we = (quot < {37'd0, used});
				wd = (rd_s1 == '1) ? rd_s1 : rd_s1 + 32'd1;
			end
			ST_RRD: addr = item_q.bucket_index[IdxW-1:0];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wd;
		rd_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			boot_q <= 1'b1;
			nb_q <= 11'd1024;
			npb_q <= 20'd1;
			ptr_q <= '0;
			done <= 1'b0;
			count_q <= '0;
			sum_q <= '0;
			min_q <= MinReset;
			max_q <= '0;
			ovf_q <= '0;
		end else begin
			state_q <= state_d;
			done <= (state_q == ST_DONE);
			if (state_q != ST_INIT) boot_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == REG_NUM_BUCKETS) nb_q <= cfg_wdata[10:0];
				else npb_q <= cfg_wdata;
			end
			case (state_q)
				ST_INIT: ptr_q <= ptr_q + 1'b1;
				ST_IDLE: begin
					ptr_q <= '0;
					if (start && in_data.kind == KIND_CLEAR) begin
						count_q <= '0;
						sum_q <= '0;
						min_q <= MinReset;
						max_q <= '0;
						ovf_q <= '0;
					end
				end
				ST_SRD: begin
					count_q <= (count_q == '1) ? count_q : count_q + 32'd1;
					sum_q <= (sum_q > ~{32'd0, item_q.sample_ns}) ? '1
						: sum_q + {32'd0, item_q.sample_ns};
					if (item_q.sample_ns > max_q) max_q <= item_q.sample_ns;
					if (item_q.sample_ns < min_q) min_q <= item_q.sample_ns;
					if (quot >= {37'd0, used} && ovf_q != '1) ovf_q <= ovf_q + 32'd1;
				end
				ST_WALK2: ptr_q <= ptr_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				item_q <= in_data;
				acc_q <= '0;
				found_q <= 1'b0;
				edge_q <= '0;
				bval_q <= '0;
				needed_q <= {17'd0, count_q} * {32'd0, in_data.percentile_milli};
			end
			ST_WALK2: begin
				acc_q <= acc_q + rd_scaled;
				prod_q <= 49'(({39'd0, ptr_q} + 49'd1) * {29'd0, width});
			end
			ST_EMUL: begin
				found_q <= 1'b1;
				edge_q <= (prod_q > {19'd0, EdgeMax}) ? EdgeMax : prod_q[29:0];
			end
			ST_RRD: bval_q <= '0;
			ST_DONE: if (item_q.kind == KIND_READ) bval_q <= rd_s1;
			default: ;
		endcase
	end

	always_comb begin
		out_data.percentile_ns = edge_q;
		out_data.percentile_found = found_q;
		out_data.bucket_value = bval_q;
		out_data.sample_count = count_q;
		out_data.sample_sum = sum_q;
		out_data.min_sample = min_q;
		out_data.max_sample = max_q;
		out_data.overflow_count = ovf_q;
	end
endmodule

@@ src/lhp_checker.sv @@
`include "latency_histogram_percentile_macros.svh"
module lhp_checker import lhp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input lhp_out_t out_data
);
	`LHP_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`LHP_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy))
	`LHP_ASSERT_IMP(a_found_edge, clk, arst_n, done && !out_data.percentile_found,
		out_data.percentile_ns == '0)
endmodule

bind latency_histogram_percentile lhp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.out_data(out_data)
);
